>>> sv/bsf_pkg.sv
`default_nettype none
package bsf_pkg;

  localparam int unsigned MaxScreenDim = 4096;
  localparam int unsigned MaxImageDim  = 65535;
  localparam int unsigned HeaderBytes  = 54;
  localparam int unsigned QueueDepthDefault = 4;

  localparam int unsigned ScreenW   = 13;
  localparam int unsigned ImageDimW = 16;
  localparam int unsigned PosW      = 18;
  localparam int unsigned ScreenPosW = 12;

  localparam logic [ScreenW-1:0] ScreenWidthReset  = 13'd800;
  localparam logic [ScreenW-1:0] ScreenHeightReset = 13'd480;

  localparam logic CfgScreenWidth  = 1'b0;
  localparam logic CfgScreenHeight = 1'b1;

  // header byte offsets of the little-endian fields
  localparam logic [5:0] OffWidth0  = 6'd18;
  localparam logic [5:0] OffWidth1  = 6'd19;
  localparam logic [5:0] OffWidth2  = 6'd20;
  localparam logic [5:0] OffWidth3  = 6'd21;
  localparam logic [5:0] OffHeight0 = 6'd22;
  localparam logic [5:0] OffHeight1 = 6'd23;
  localparam logic [5:0] OffHeight2 = 6'd24;
  localparam logic [5:0] OffHeight3 = 6'd25;
  localparam logic [5:0] OffBpp0    = 6'd28;
  localparam logic [5:0] OffBpp1    = 6'd29;
  localparam logic [5:0] OffLast    = 6'(HeaderBytes - 1);

  localparam logic [15:0] Bpp24 = 16'd24;
  localparam logic [15:0] Bpp32 = 16'd32;

  localparam logic [1:0] ByteRed   = 2'd2;
  localparam logic [1:0] ByteLast3 = 2'd2;
  localparam logic [1:0] ByteLast4 = 2'd3;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PIXELS = 2'd1,
    PH_DONE   = 2'd2,
    PH_REJECT = 2'd3
  } bsf_phase_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_UNSUPPORTED = 2'd1,
    ST_SHORT       = 2'd2,
    ST_UNUSED      = 2'd3
  } bsf_status_e;

  typedef enum logic {
    KIND_PIXEL  = 1'b0,
    KIND_STATUS = 1'b1
  } bsf_kind_e;

  typedef struct packed {
    logic                 pix_en;
    logic [ImageDimW-1:0] col;
    logic [ImageDimW-1:0] row;
    logic [23:0]          rgb;
    logic [ImageDimW-1:0] width;
    logic [ImageDimW-1:0] height;
    logic                 stat_en;
    bsf_status_e          status;
  } bsf_entry_t;

endpackage
`default_nettype wire

>>> sv/bmp_stream_to_framebuffer.sv
// Channel | Direction | Handshake              | Payload
// input   | in        | in_valid_i / in_stall_o | data_byte_i, end_of_file_i
// result  | out       | out_valid_o / out_stall_i | result_kind_o, pixel_index_o,
//         |           |                        | pixel_rgb_o, status_o, last_result_o
// config  | in        | cfg_we_i               | cfg_index_i, cfg_data_i
//
// One byte is taken per cycle while in_stall_o is low; a byte that yields a result beat
// goes through the queue write, the offset stage and the multiply into the output register.
// A byte that yields a pixel write and a status report sends the pixel beat first.
// in_stall_o rises only while the queue between parser and output side is full.
// Reset restores 800x480 and puts the parser at the start of a header.
`default_nettype none
module bmp_stream_to_framebuffer import bsf_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_index_i,
  input  wire logic [ScreenW-1:0] cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         data_byte_i,
  input  wire logic               end_of_file_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    result_kind_o,
  output logic [23:0]             pixel_index_o,
  output logic [23:0]             pixel_rgb_o,
  output logic [1:0]              status_o,
  output logic                    last_result_o
);

  logic [ScreenW-1:0] sw_q, sh_q;
  logic       full, accept, push, q_valid, q_pop;
  bsf_entry_t f_entry, q_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= ScreenWidthReset;
      sh_q <= ScreenHeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgScreenWidth:  sw_q <= cfg_data_i;
        CfgScreenHeight: sh_q <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  bsf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .end_of_file_i (end_of_file_i),
    .push_o        (push),
    .entry_o       (f_entry)
  );

  bsf_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (f_entry),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  bsf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .screen_width_i  (sw_q),
    .screen_height_i (sh_q),
    .q_valid_i       (q_valid),
    .q_entry_i       (q_entry),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_kind_o   (result_kind_o),
    .pixel_index_o   (pixel_index_o),
    .pixel_rgb_o     (pixel_rgb_o),
    .status_o        (status_o),
    .last_result_o   (last_result_o)
  );

endmodule
`default_nettype wire

>>> sv/bsf_front.sv
`default_nettype none
module bsf_front import bsf_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       end_of_file_i,
  output logic            push_o,
  output bsf_entry_t      entry_o
);

  bsf_phase_e phase_q, phase_d, phase_upd;
  logic [5:0]  hdr_off_q, hdr_off_d;
  logic [31:0] width_q, width_d;
  logic [31:0] height_q, height_d;
  logic [15:0] bpp_q, bpp_d;
  logic [ImageDimW-1:0] col_q, col_d, row_q, row_d;
  logic [1:0]  bip_q, bip_d, pad_q, pad_d;
  logic [15:0] bg_q, bg_d;
  logic        err_q, err_d;

  logic        hdr_last, hdr_ok, pix_byte, pix_last_byte, col_last, row_end, last_row;
  logic [31:0] hmag;
  logic [1:0]  pad_new;
  logic        is_red;

  always_comb begin
    hmag          = height_q[31] ? (~height_q + 32'd1) : height_q;
    hdr_last      = (phase_q == PH_HEADER) && (hdr_off_q == OffLast);
    hdr_ok        = ((bpp_q == Bpp24) || (bpp_q == Bpp32)) &&
                    (width_q != 32'd0) && (width_q[31:16] == 16'd0) &&
                    (hmag != 32'd0) && (hmag[31:16] == 16'd0);
    pix_byte      = (phase_q == PH_PIXELS) && (pad_q == 2'd0);
    pix_last_byte = pix_byte && ((bpp_q == Bpp32) ? (bip_q == ByteLast4) : (bip_q == ByteLast3));
    col_last      = pix_last_byte &&
                    (({1'b0, col_q} + 17'd1) >= {1'b0, width_q[ImageDimW-1:0]});
    pad_new       = (bpp_q == Bpp32) ? 2'd0 : width_q[1:0];
    row_end       = (phase_q == PH_PIXELS) &&
                    (((pad_q != 2'd0) && (pad_q == 2'd1)) || (col_last && (pad_new == 2'd0)));
    last_row      = ({1'b0, row_q} + 17'd1) >= {1'b0, hmag[ImageDimW-1:0]};
    is_red        = pix_byte && (bip_q == ByteRed);
  end

  // next phase
  always_comb begin
    phase_upd = phase_q;
    unique case (phase_q)
      PH_HEADER: if (hdr_last) phase_upd = hdr_ok ? PH_PIXELS : PH_REJECT;
      PH_PIXELS: if (row_end && last_row) phase_upd = PH_DONE;
      PH_DONE:   phase_upd = PH_DONE;
      PH_REJECT: phase_upd = PH_REJECT;
      default:   phase_upd = PH_HEADER;
    endcase
    phase_d = end_of_file_i ? PH_HEADER : phase_upd;
  end

  // counters, fields and queue entry
  always_comb begin
    hdr_off_d = hdr_off_q;
    width_d   = width_q;
    height_d  = height_q;
    bpp_d     = bpp_q;
    col_d     = col_q;
    row_d     = row_q;
    bip_d     = bip_q;
    pad_d     = pad_q;
    bg_d      = bg_q;
    err_d     = err_q;

    if (phase_q == PH_HEADER) begin
      unique case (hdr_off_q)
        OffWidth0:  width_d[7:0]    = data_byte_i;
        OffWidth1:  width_d[15:8]   = data_byte_i;
        OffWidth2:  width_d[23:16]  = data_byte_i;
        OffWidth3:  width_d[31:24]  = data_byte_i;
        OffHeight0: height_d[7:0]   = data_byte_i;
        OffHeight1: height_d[15:8]  = data_byte_i;
        OffHeight2: height_d[23:16] = data_byte_i;
        OffHeight3: height_d[31:24] = data_byte_i;
        OffBpp0:    bpp_d[7:0]      = data_byte_i;
        OffBpp1:    bpp_d[15:8]     = data_byte_i;
        default:    ;
      endcase
      if (hdr_last) begin
        col_d = '0;
        row_d = '0;
        bip_d = '0;
        pad_d = '0;
        if (!hdr_ok) err_d = 1'b1;
      end else begin
        hdr_off_d = hdr_off_q + 6'd1;
      end
    end else if (phase_q == PH_PIXELS) begin
      if (pad_q != 2'd0) begin
        pad_d = pad_q - 2'd1;
      end else begin
        if (bip_q == 2'd0) bg_d = {8'd0, data_byte_i};
        else if (bip_q == 2'd1) bg_d = {data_byte_i, bg_q[7:0]};
        if (pix_last_byte) begin
          bip_d = '0;
          col_d = col_q + 16'd1;
          if (col_last) pad_d = pad_new;
        end else begin
          bip_d = bip_q + 2'd1;
        end
      end
      if (row_end) begin
        col_d = '0;
        row_d = row_q + 16'd1;
      end
    end

    entry_o.pix_en  = is_red;
    entry_o.col     = col_q;
    entry_o.row     = height_q[31] ? row_q : (hmag[ImageDimW-1:0] - 16'd1 - row_q);
    entry_o.rgb     = {data_byte_i, bg_q};
    entry_o.width   = width_q[ImageDimW-1:0];
    entry_o.height  = hmag[ImageDimW-1:0];
    entry_o.stat_en = end_of_file_i;
    if (err_d) entry_o.status = ST_UNSUPPORTED;
    else if (phase_upd == PH_DONE) entry_o.status = ST_OK;
    else entry_o.status = ST_SHORT;
    push_o = accept_i && (is_red || end_of_file_i);

    if (end_of_file_i) begin
      hdr_off_d = '0;
      width_d   = '0;
      height_d  = '0;
      bpp_d     = '0;
      col_d     = '0;
      row_d     = '0;
      bip_d     = '0;
      pad_d     = '0;
      bg_d      = '0;
      err_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      hdr_off_q <= '0;
      width_q   <= '0;
      height_q  <= '0;
      bpp_q     <= '0;
      col_q     <= '0;
      row_q     <= '0;
      bip_q     <= '0;
      pad_q     <= '0;
      bg_q      <= '0;
      err_q     <= 1'b0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      hdr_off_q <= hdr_off_d;
      width_q   <= width_d;
      height_q  <= height_d;
      bpp_q     <= bpp_d;
      col_q     <= col_d;
      row_q     <= row_d;
      bip_q     <= bip_d;
      pad_q     <= pad_d;
      bg_q      <= bg_d;
      err_q     <= err_d;
    end
  end

endmodule
`default_nettype wire

>>> sv/bsf_queue.sv
`default_nettype none
module bsf_queue import bsf_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire bsf_entry_t entry_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output logic            valid_o,
  output bsf_entry_t      entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bsf_entry_t          mem_q [Depth];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    full_o  = (cnt_q == CntW'(Depth));
    valid_o = (cnt_q != '0);
    entry_o = mem_q[rd_q];
    wr_d    = push_i ? ptr_inc(wr_q) : wr_q;
    rd_d    = pop_i ? ptr_inc(rd_q) : rd_q;
    cnt_d   = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i)) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o)) else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth)) else $error("queue count out of range");

endmodule
`default_nettype wire

>>> sv/bsf_back.sv
`default_nettype none
module bsf_back import bsf_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [ScreenW-1:0] screen_width_i,
  input  wire logic [ScreenW-1:0] screen_height_i,
  input  wire logic               q_valid_i,
  input  wire bsf_entry_t         q_entry_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    result_kind_o,
  output logic [23:0]             pixel_index_o,
  output logic [23:0]             pixel_rgb_o,
  output logic [1:0]              status_o,
  output logic                    last_result_o
);

  logic [ScreenW-1:0] swc, shc;
  logic signed [PosW-1:0] dx, dy, hx, hy, sx, sy;
  logic vis;

  logic                  s1_valid_q, s1_valid_d, s1_vis_q, s1_stat_q, s1_sent_q, s1_sent_d;
  logic [ScreenPosW-1:0] s1_sx_q, s1_sy_q;
  logic [ScreenW-1:0]    s1_sw_q;
  logic [23:0]           s1_rgb_q;
  bsf_status_e           s1_status_q;

  logic        out_valid_q, out_valid_d;
  bsf_kind_e   kind_q;
  logic [23:0] idx_q, rgb_q;
  bsf_status_e st_q;
  logic        last_q;

  logic out_free, emit_pix, emit_st, load_out, s1_pop, s1_load;
  logic [24:0] prod, idx_sum;

  function automatic logic [ScreenW-1:0] clamp_dim(input logic [ScreenW-1:0] v);
    if (v == '0) clamp_dim = ScreenW'(1);
    else if (v > ScreenW'(MaxScreenDim)) clamp_dim = ScreenW'(MaxScreenDim);
    else clamp_dim = v;
  endfunction

  // centering offsets truncate toward zero
  always_comb begin
    swc = clamp_dim(screen_width_i);
    shc = clamp_dim(screen_height_i);
    dx  = $signed({5'd0, swc}) - $signed({2'd0, q_entry_i.width});
    dy  = $signed({5'd0, shc}) - $signed({2'd0, q_entry_i.height});
    hx  = (dx >>> 1) + $signed({17'd0, dx[PosW-1] & dx[0]});
    hy  = (dy >>> 1) + $signed({17'd0, dy[PosW-1] & dy[0]});
    sx  = hx + $signed({2'd0, q_entry_i.col});
    sy  = hy + $signed({2'd0, q_entry_i.row});
    vis = q_entry_i.pix_en && !sx[PosW-1] && !sy[PosW-1] &&
          (sx < $signed({5'd0, swc})) && (sy < $signed({5'd0, shc}));
  end

  always_comb begin
    out_free = !out_valid_q || !out_stall_i;
    emit_pix = s1_valid_q && s1_vis_q && !s1_sent_q;
    emit_st  = s1_valid_q && s1_stat_q && !emit_pix;
    load_out = out_free && (emit_pix || emit_st);
    // drop a clipped pixel with no status right away
    s1_pop   = s1_valid_q && ((!emit_pix && !emit_st) || (out_free && emit_st) ||
                              (out_free && emit_pix && !s1_stat_q));
    s1_load  = q_valid_i && (!s1_valid_q || s1_pop);
    q_pop_o  = s1_load;
    s1_valid_d = s1_load ? 1'b1 : (s1_pop ? 1'b0 : s1_valid_q);
    if (s1_load) s1_sent_d = 1'b0;
    else if (out_free && emit_pix && s1_stat_q) s1_sent_d = 1'b1;
    else s1_sent_d = s1_sent_q;
    if (load_out) out_valid_d = 1'b1;
    else if (out_free) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
    prod    = {13'd0, s1_sy_q} * {12'd0, s1_sw_q};
    idx_sum = prod + {13'd0, s1_sx_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_sent_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      s1_sent_q   <= s1_sent_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_vis_q    <= vis;
      s1_stat_q   <= q_entry_i.stat_en;
      s1_sx_q     <= sx[ScreenPosW-1:0];
      s1_sy_q     <= sy[ScreenPosW-1:0];
      s1_sw_q     <= swc;
      s1_rgb_q    <= q_entry_i.rgb;
      s1_status_q <= q_entry_i.status;
    end
    if (load_out) begin
      if (emit_pix) begin
        kind_q <= KIND_PIXEL;
        idx_q  <= idx_sum[23:0];
        rgb_q  <= s1_rgb_q;
        st_q   <= ST_OK;
        last_q <= !s1_stat_q;
      end else begin
        kind_q <= KIND_STATUS;
        idx_q  <= '0;
        rgb_q  <= '0;
        st_q   <= s1_status_q;
        last_q <= 1'b1;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign pixel_index_o = idx_q;
  assign pixel_rgb_o   = rgb_q;
  assign status_o      = st_q;
  assign last_result_o = last_q;

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == KIND_STATUS |-> last_q && idx_q == '0 && rgb_q == '0)
    else $error("status beat malformed");
  a_pixel_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == KIND_PIXEL |-> st_q == ST_OK)
    else $error("pixel beat carries status");
  a_split_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_pop |=> s1_valid_q && $stable(s1_rgb_q))
    else $error("stage lost while waiting");

endmodule
`default_nettype wire
